// ----- design/psnc_pkg.sv -----
// Shared types, widths and codes of the point store with nearest and centroid search.
package psnc_pkg;

    // Store size and field widths.
    localparam int MAX_POINTS  = 1024;
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = 11;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int IDXC_W      = CNT_W + 1;
    localparam int SUM_W       = COORD_W + ADDR_W + 1;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int MAG_W       = COORD_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int WORD_W      = 2 * COORD_W;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Operation codes of a request.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_NEAREST  = 2'd1,
        OP_READ     = 2'd2,
        OP_CENTROID = 2'd3
    } op_t;

    // Status codes of a result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_TAKE,
        S_SCAN,
        S_DRAIN,
        S_DIVIDE,
        S_DIV_TAKE,
        S_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic append;
        logic set_empty;
        logic set_range;
        logic read_issue;
        logic read_take;
        logic scan_start;
        logic scan_issue;
        logic scan_take;
        logic div_start;
        logic div_step;
        logic div_take;
        logic load_out;
    } psnc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic empty;
        logic range_bad;
        logic scan_last;
        logic pipe_busy;
        logic div_last;
        logic out_free;
    } psnc_stat_t;

endpackage

// ----- design/psnc_if.sv -----
// Request and result channel interfaces of the point store.
interface psnc_req_if import psnc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             op;
    logic signed [COORD_W-1:0]   coord_x;
    logic signed [COORD_W-1:0]   coord_y;
    logic signed [POS_W-1:0]     position;

    modport source (output valid, output op, output coord_x, output coord_y,
                    output position, input ready);
    modport sink   (input valid, input op, input coord_x, input coord_y,
                    input position, output ready);
endinterface

interface psnc_rsp_if import psnc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_W-1:0]   result_x;
    logic signed [COORD_W-1:0]   result_y;
    logic [ADDR_W-1:0]           found_index;
    logic [CNT_W-1:0]            stored_count;
    logic [STATUS_W-1:0]         status;

    modport source (output valid, output result_x, output result_y,
                    output found_index, output stored_count, output status,
                    input ready);
    modport sink   (input valid, input result_x, input result_y,
                    input found_index, input stored_count, input status,
                    output ready);
endinterface

// ----- design/psnc_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
module psnc_ctrl import psnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  psnc_stat_t stat,
    output psnc_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_APPEND:   state_next = S_FINISH;
                    OP_NEAREST:  state_next = stat.empty ? S_FINISH : S_SCAN;
                    OP_READ:     state_next = stat.range_bad ? S_FINISH : S_READ_TAKE;
                    OP_CENTROID: state_next = stat.empty ? S_FINISH : S_DIVIDE;
                    default:     state_next = S_FINISH;
                endcase
            end
            S_READ_TAKE: state_next = S_FINISH;
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIVIDE:
            begin
                if (stat.div_last)
                begin
                    state_next = S_DIV_TAKE;
                end
            end
            S_DIV_TAKE: state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands and request ready.
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_APPEND:
                    begin
                        cmd.append = 1'b1;
                    end
                    OP_NEAREST:
                    begin
                        cmd.set_empty  = stat.empty;
                        cmd.scan_start = !stat.empty;
                    end
                    OP_READ:
                    begin
                        cmd.set_range  = stat.range_bad;
                        cmd.read_issue = !stat.range_bad;
                    end
                    OP_CENTROID:
                    begin
                        cmd.set_empty = stat.empty;
                        cmd.div_start = !stat.empty;
                    end
                    default:
                    begin
                        cmd.set_empty = 1'b1;
                    end
                endcase
            end
            S_READ_TAKE: cmd.read_take  = 1'b1;
            S_SCAN:      cmd.scan_issue = 1'b1;
            S_DRAIN:     cmd.scan_take  = !stat.pipe_busy;
            S_DIVIDE:    cmd.div_step   = 1'b1;
            S_DIV_TAKE:  cmd.div_take   = 1'b1;
            S_FINISH:    cmd.load_out   = stat.out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/psnc_dp.sv -----
// Datapath: point memory, count and sums, distance pipeline, divider and result registers.
module psnc_dp import psnc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [OP_W-1:0]            in_op,
    input  logic signed [COORD_W-1:0]  in_x,
    input  logic signed [COORD_W-1:0]  in_y,
    input  logic signed [POS_W-1:0]    in_pos,
    input  psnc_cmd_t                  cmd,
    output psnc_stat_t                 stat,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [COORD_W-1:0]  out_x,
    output logic signed [COORD_W-1:0]  out_y,
    output logic [ADDR_W-1:0]          out_idx,
    output logic [CNT_W-1:0]           out_count,
    output logic [STATUS_W-1:0]        out_status
);

    // Latched request.
    logic [OP_W-1:0]            op_reg;
    logic signed [COORD_W-1:0]  qx_reg;
    logic signed [COORD_W-1:0]  qy_reg;
    logic signed [POS_W-1:0]    pos_reg;

    // Store state.
    logic [CNT_W-1:0]           count_reg;
    logic signed [SUM_W-1:0]    sum_x_reg;
    logic signed [SUM_W-1:0]    sum_y_reg;
    logic [WORD_W-1:0]          mem [MAX_POINTS];
    logic [WORD_W-1:0]          rd_data_reg;

    // Read index.
    logic signed [IDXC_W-1:0]   pos_ext;
    logic signed [IDXC_W-1:0]   idx_calc;
    logic                       full;
    logic                       empty;
    logic                       range_bad;

    // Memory port.
    logic                       mem_rd;
    logic [ADDR_W-1:0]          rd_addr;

    // Scan pipeline.
    logic [ADDR_W-1:0]          scan_addr_reg;
    logic                       s1_valid_reg;
    logic [ADDR_W-1:0]          s1_idx_reg;
    logic                       s2_valid_reg;
    logic [ADDR_W-1:0]          s2_idx_reg;
    logic [MAG_W-1:0]           s2_dx_reg;
    logic [MAG_W-1:0]           s2_dy_reg;
    logic [WORD_W-1:0]          s2_pt_reg;
    logic                       s3_valid_reg;
    logic [ADDR_W-1:0]          s3_idx_reg;
    logic [SQ_W-1:0]            s3_sx_reg;
    logic [SQ_W-1:0]            s3_sy_reg;
    logic [WORD_W-1:0]          s3_pt_reg;
    logic                       best_valid_reg;
    logic [DIST_W-1:0]          best_dist_reg;
    logic [ADDR_W-1:0]          best_idx_reg;
    logic [WORD_W-1:0]          best_pt_reg;
    logic signed [COORD_W-1:0]  rd_px;
    logic signed [COORD_W-1:0]  rd_py;
    logic signed [DIFF_W-1:0]   diff_x;
    logic signed [DIFF_W-1:0]   diff_y;
    logic [MAG_W-1:0]           mag_x;
    logic [MAG_W-1:0]           mag_y;
    logic [SQ_W-1:0]            sq_x;
    logic [SQ_W-1:0]            sq_y;
    logic [DIST_W-1:0]          sq_sum;
    logic                       better;

    // Divider.
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic                       neg_x_reg;
    logic                       neg_y_reg;
    logic [SUM_W-1:0]           quo_x_reg;
    logic [SUM_W-1:0]           quo_y_reg;
    logic [CNT_W-1:0]           rem_x_reg;
    logic [CNT_W-1:0]           rem_y_reg;
    logic [CNT_W:0]             rem_x_sh;
    logic [CNT_W:0]             rem_y_sh;
    logic                       bit_x;
    logic                       bit_y;
    logic [CNT_W-1:0]           rem_x_next;
    logic [CNT_W-1:0]           rem_y_next;
    logic [SUM_W-1:0]           fin_x;
    logic [SUM_W-1:0]           fin_y;

    // Pending and output results.
    logic signed [COORD_W-1:0]  res_x_reg;
    logic signed [COORD_W-1:0]  res_y_reg;
    logic [ADDR_W-1:0]          res_idx_reg;
    status_t                    res_status_reg;
    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic [ADDR_W-1:0]          out_idx_reg;
    logic [CNT_W-1:0]           out_count_reg;
    logic [STATUS_W-1:0]        out_status_reg;

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= in_op;
            qx_reg  <= in_x;
            qy_reg  <= in_y;
            pos_reg <= in_pos;
        end
    end

    // Store status and read index; a negative position counts back from the end.
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign empty     = (count_reg == '0);
    assign pos_ext   = IDXC_W'(pos_reg);
    assign idx_calc  = pos_reg[POS_W-1] ? ($signed({1'b0, count_reg}) + pos_ext) : pos_ext;
    assign range_bad = idx_calc[IDXC_W-1] || (idx_calc[CNT_W-1:0] >= count_reg);

    // Count and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (cmd.append && !full)
        begin
            count_reg <= count_reg + CNT_W'(1);
            sum_x_reg <= sum_x_reg + SUM_W'(qx_reg);
            sum_y_reg <= sum_y_reg + SUM_W'(qy_reg);
        end
    end

    // Point memory, one write or one read per cycle.
    assign mem_rd  = cmd.read_issue || cmd.scan_issue;
    assign rd_addr = cmd.read_issue ? idx_calc[ADDR_W-1:0] : scan_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {qx_reg, qy_reg};
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Scan address and pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
            end
            s1_valid_reg <= cmd.scan_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.scan_start)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (s3_valid_reg)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    // Absolute coordinate differences from the fetched point.
    assign rd_px  = $signed(rd_data_reg[WORD_W-1:COORD_W]);
    assign rd_py  = $signed(rd_data_reg[COORD_W-1:0]);
    assign diff_x = DIFF_W'(qx_reg) - DIFF_W'(rd_px);
    assign diff_y = DIFF_W'(qy_reg) - DIFF_W'(rd_py);
    assign mag_x  = diff_x[DIFF_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
    assign mag_y  = diff_y[DIFF_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);

    // Squares.
    assign sq_x = s2_dx_reg * s2_dx_reg;
    assign sq_y = s2_dy_reg * s2_dy_reg;

    // Sum and compare; a strict less-than keeps the lowest index on ties.
    assign sq_sum = DIST_W'(s3_sx_reg) + DIST_W'(s3_sy_reg);
    assign better = !best_valid_reg || (sq_sum < best_dist_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            s1_idx_reg <= scan_addr_reg;
        end
        s2_idx_reg <= s1_idx_reg;
        s2_dx_reg  <= mag_x;
        s2_dy_reg  <= mag_y;
        s2_pt_reg  <= rd_data_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_sx_reg  <= sq_x;
        s3_sy_reg  <= sq_y;
        s3_pt_reg  <= s2_pt_reg;
        if (s3_valid_reg && better)
        begin
            best_dist_reg <= sq_sum;
            best_idx_reg  <= s3_idx_reg;
            best_pt_reg   <= s3_pt_reg;
        end
    end

    // Restoring divider step, one quotient bit per cycle for both sums.
    assign rem_x_sh   = {rem_x_reg, quo_x_reg[SUM_W-1]};
    assign rem_y_sh   = {rem_y_reg, quo_y_reg[SUM_W-1]};
    assign bit_x      = (rem_x_sh >= {1'b0, count_reg});
    assign bit_y      = (rem_y_sh >= {1'b0, count_reg});
    assign rem_x_next = bit_x ? CNT_W'(rem_x_sh - {1'b0, count_reg}) : CNT_W'(rem_x_sh);
    assign rem_y_next = bit_y ? CNT_W'(rem_y_sh - {1'b0, count_reg}) : CNT_W'(rem_y_sh);
    assign fin_x      = neg_x_reg ? (~quo_x_reg + SUM_W'(1)) : quo_x_reg;
    assign fin_y      = neg_y_reg ? (~quo_y_reg + SUM_W'(1)) : quo_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_x_reg <= sum_x_reg[SUM_W-1];
            neg_y_reg <= sum_y_reg[SUM_W-1];
            quo_x_reg <= sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
            quo_y_reg <= sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_x_reg <= {quo_x_reg[SUM_W-2:0], bit_x};
            quo_y_reg <= {quo_y_reg[SUM_W-2:0], bit_y};
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
    end

    // Pending result, set by whichever operation finishes.
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_idx_reg    <= '0;
            res_status_reg <= full ? ST_FULL : ST_OK;
        end
        else if (cmd.set_empty || cmd.set_range)
        begin
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_idx_reg    <= '0;
            res_status_reg <= cmd.set_range ? ST_RANGE : ST_EMPTY;
        end
        else if (cmd.read_issue)
        begin
            res_idx_reg <= idx_calc[ADDR_W-1:0];
        end
        else if (cmd.read_take)
        begin
            res_x_reg      <= rd_px;
            res_y_reg      <= rd_py;
            res_status_reg <= ST_OK;
        end
        else if (cmd.scan_take)
        begin
            res_x_reg      <= $signed(best_pt_reg[WORD_W-1:COORD_W]);
            res_y_reg      <= $signed(best_pt_reg[COORD_W-1:0]);
            res_idx_reg    <= best_idx_reg;
            res_status_reg <= ST_OK;
        end
        else if (cmd.div_take)
        begin
            res_x_reg      <= $signed(fin_x[COORD_W-1:0]);
            res_y_reg      <= $signed(fin_y[COORD_W-1:0]);
            res_idx_reg    <= '0;
            res_status_reg <= ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_idx_reg    <= res_idx_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Status to the controller.
    assign stat.op        = op_t'(op_reg);
    assign stat.empty     = empty;
    assign stat.range_bad = range_bad;
    assign stat.scan_last = (CNT_W'(scan_addr_reg) + CNT_W'(1)) == count_reg;
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign stat.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_idx    = out_idx_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

endmodule

// ----- design/point_store_nearest_centroid.sv -----
// Top level of the point store with nearest-point search, indexed read and centroid.
//
// The block holds up to 1024 points of signed 16-bit x and y in one single-port memory
// and handles one request at a time. A centroid uses a restoring divider that yields one
// quotient bit per cycle over the 27-bit sums, and a nearest search streams each stored
// point from the memory port, one point per cycle, into a four-stage distance pipeline.
// A nearest or centroid request on an empty store returns status empty, an append to a
// full store drops the point with status full, and a read outside the stored points
// returns status out of range. A finished result waits in an output register, so the
// next request is taken while it is still unread. Stored entries need no clearing
// after reset.
module point_store_nearest_centroid import psnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    psnc_req_if.sink   req,
    psnc_rsp_if.source rsp
);

    psnc_cmd_t  cmd;
    psnc_stat_t stat;

    // Request sequencing.
    psnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    psnc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (req.op),
        .in_x       (req.coord_x),
        .in_y       (req.coord_y),
        .in_pos     (req.position),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_x      (rsp.result_x),
        .out_y      (rsp.result_y),
        .out_idx    (rsp.found_index),
        .out_count  (rsp.stored_count),
        .out_status (rsp.status)
    );

`ifndef ASSERT_OFF
    // A dropped append is reported only when the store is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> rsp.stored_count == CNT_W'(MAX_POINTS))
    else $error("full status with store below capacity");

    // An empty status comes only from an empty store and carries zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_EMPTY) |->
            (rsp.stored_count == '0) && (rsp.result_x == '0) && (rsp.result_y == '0))
    else $error("empty status with stored points or nonzero result");

    // An out-of-range read returns zero point and index.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_RANGE) |->
            (rsp.found_index == '0) && (rsp.result_x == '0) && (rsp.result_y == '0))
    else $error("out-of-range read with nonzero fields");

    // A request is never taken while the controller is busy with the previous one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
    else $error("request accepted in consecutive cycles");
`endif

endmodule
